>>> design/s8b_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s8b_pkg
// Shared types, constants and field helpers for the Simple-8b word decoder.
// ----------------------------------------------------------------------------
package s8b_pkg;

  localparam int unsigned WordWidth    = 64;
  localparam int unsigned PayloadWidth = 60;
  localparam int unsigned SelWidth     = 4;
  localparam int unsigned CountWidth   = 6;

  localparam logic [SelWidth-1:0] SelZeroRun  = 4'd0;
  localparam logic [SelWidth-1:0] SelContinue = 4'd15;

  // selectors whose fields leave the top four payload bits unused
  localparam logic [SelWidth-1:0] SelSevenBit = 4'd7;
  localparam logic [SelWidth-1:0] SelEightBit = 4'd8;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Number of packed fields for a field selector.
  function automatic logic [CountWidth-1:0] field_count(input logic [SelWidth-1:0] sel);
    logic [CountWidth-1:0] n;
    unique case (sel)
      4'd1:    n = 6'd60;
      4'd2:    n = 6'd30;
      4'd3:    n = 6'd20;
      4'd4:    n = 6'd15;
      4'd5:    n = 6'd12;
      4'd6:    n = 6'd10;
      4'd7:    n = 6'd8;
      4'd8:    n = 6'd7;
      4'd9:    n = 6'd6;
      4'd10:   n = 6'd5;
      4'd11:   n = 6'd4;
      4'd12:   n = 6'd3;
      4'd13:   n = 6'd2;
      default: n = 6'd1;
    endcase
    return n;
  endfunction

  // Top field of a left-aligned payload, zero-extended.
  function automatic logic [PayloadWidth-1:0] field_top(input logic [SelWidth-1:0] sel,
                                                        input logic [PayloadWidth-1:0] w);
    logic [PayloadWidth-1:0] v;
    unique case (sel)
      4'd0:    v = '0;
      4'd1:    v = 60'(w[59:59]);
      4'd2:    v = 60'(w[59:58]);
      4'd3:    v = 60'(w[59:57]);
      4'd4:    v = 60'(w[59:56]);
      4'd5:    v = 60'(w[59:55]);
      4'd6:    v = 60'(w[59:54]);
      4'd7:    v = 60'(w[59:53]);
      4'd8:    v = 60'(w[59:52]);
      4'd9:    v = 60'(w[59:50]);
      4'd10:   v = 60'(w[59:48]);
      4'd11:   v = 60'(w[59:45]);
      4'd12:   v = 60'(w[59:40]);
      4'd13:   v = 60'(w[59:30]);
      default: v = w;
    endcase
    return v;
  endfunction

  // Shift the payload left by one field width.
  function automatic logic [PayloadWidth-1:0] field_shift(input logic [SelWidth-1:0] sel,
                                                          input logic [PayloadWidth-1:0] w);
    logic [PayloadWidth-1:0] v;
    unique case (sel)
      4'd1:    v = w << 1;
      4'd2:    v = w << 2;
      4'd3:    v = w << 3;
      4'd4:    v = w << 4;
      4'd5:    v = w << 5;
      4'd6:    v = w << 6;
      4'd7:    v = w << 7;
      4'd8:    v = w << 8;
      4'd9:    v = w << 10;
      4'd10:   v = w << 12;
      4'd11:   v = w << 15;
      4'd12:   v = w << 20;
      4'd13:   v = w << 30;
      default: v = w;
    endcase
    return v;
  endfunction

endpackage

>>> design/simple8b_word_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simple8b_word_decoder
// Unpacks one Simple-8b word into its integers, one per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall carries one 64-bit packed_word per
//   transfer. Output channel out_valid / out_stall carries one decoded value
//   per transfer with continued, last_of_word and run_too_long flags.
//   A word is accepted only while the sequencer is idle; it then yields n
//   results, n being the field count (1..60) or the zero-run length
//   (1..RUN_LIMIT). One result per cycle comes from a shared field
//   extract/shift unit; the first reaches the output register after the
//   word has been loaded into the working registers. The sequencer goes
//   back to idle with its last result and only then takes the next word,
//   so no new word is taken before the last has yielded all n results.
//   The last result may still sit in the output register while the next
//   word is accepted. When the receiver stalls, the output register holds
//   its result and the sequencer waits, and no result is lost.
//   Reset (rst, synchronous) returns the sequencer to idle and empties the
//   output register.
// ----------------------------------------------------------------------------
module simple8b_word_decoder
  import s8b_pkg::*;
#(
  parameter int unsigned RUN_LIMIT = 63
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [WordWidth-1:0]    packed_word,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [PayloadWidth-1:0] value,
  output logic                    continued,
  output logic                    last_of_word,
  output logic                    run_too_long
);

  state_t                  state, state_next;
  logic [PayloadWidth-1:0] word;
  logic [SelWidth-1:0]     sel;
  logic [CountWidth-1:0]   cnt;
  logic                    too_long;

  logic                    load;
  logic                    emit;
  logic                    is_last;
  logic [SelWidth-1:0]     in_sel;
  logic [PayloadWidth-1:0] in_payload;
  logic                    in_too_long;
  logic [CountWidth-1:0]   in_cnt;

  assign in_sel     = packed_word[WordWidth-1 -: SelWidth];
  assign in_payload = packed_word[PayloadWidth-1:0];
  assign is_last    = (cnt == CountWidth'(1));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (load) state_next = ST_RUN;
      ST_RUN:  if (emit && is_last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    emit     = 1'b0;
    unique case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_RUN:  emit = !out_valid || !out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  assign load = in_valid && !in_stall;

  // Word setup: result count and overlong-run check
  always_comb begin
    in_too_long = 1'b0;
    priority if (in_sel == SelZeroRun) begin
      if (in_payload > PayloadWidth'(RUN_LIMIT)) begin
        in_too_long = 1'b1;
        in_cnt      = CountWidth'(1);
      end else if (in_payload[CountWidth-1:0] == '0) begin
        in_cnt = CountWidth'(1);
      end else begin
        in_cnt = in_payload[CountWidth-1:0];
      end
    end else if (in_sel == SelContinue) begin
      in_cnt = CountWidth'(1);
    end else begin
      in_cnt = field_count(in_sel);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers: left-aligned payload, selector, remaining count, overlong flag
  always_ff @(posedge clk) begin
    if (load) begin
      // selectors 7 and 8 leave the top four payload bits unused
      if (in_sel == SelSevenBit || in_sel == SelEightBit) begin
        word <= in_payload << 4;
      end else begin
        word <= in_payload;
      end
      sel      <= in_sel;
      cnt      <= in_cnt;
      too_long <= in_too_long;
    end else if (emit) begin
      word <= field_shift(sel, word);
      cnt  <= cnt - CountWidth'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      value        <= field_top(sel, word);
      continued    <= (sel == SelContinue);
      last_of_word <= is_last;
      run_too_long <= too_long;
    end
  end

endmodule

>>> bench/s8b_decode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s8b_decode_checker
// Watches both channels of the Simple-8b word decoder. Each accepted word is
// unpacked here into the values it must yield. Each value that leaves the
// decoder is compared, field by field, with the oldest one still pending.
// ----------------------------------------------------------------------------
module s8b_decode_checker
  import s8b_pkg::*;
#(
  parameter int unsigned RUN_LIMIT = 63
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [WordWidth-1:0]    packed_word,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [PayloadWidth-1:0] value,
  input  logic                    continued,
  input  logic                    last_of_word,
  input  logic                    run_too_long,
  output int                      mismatch_count,
  output int                      outstanding,
  output int                      words_seen,
  output int                      results_seen
);

  typedef struct packed {
    logic [PayloadWidth-1:0] value;
    logic                    continued;
    logic                    last;
    logic                    too_long;
  } decoded_value_t;

  // values still owed by the decoder, oldest first
  decoded_value_t pending_values[$];

  // bits per packed field for the field selectors
  function automatic int field_width(input logic [SelWidth-1:0] sel);
    int width;
    case (int'(sel))
      9:       width = 10;
      10:      width = 12;
      11:      width = 15;
      12:      width = 20;
      13:      width = 30;
      14:      width = 60;
      default: width = int'(sel);
    endcase
    return width;
  endfunction

  // Append one value at the tail of the pending list
  task automatic owe_value(input decoded_value_t item);
    pending_values.insert(pending_values.size(), item);
  endtask

  // Queue every value that one word decodes to
  task automatic unpack_word(input logic [WordWidth-1:0] word);
    logic [SelWidth-1:0]     sel;
    logic [PayloadWidth-1:0] payload;
    logic [63:0]             mask;
    decoded_value_t          item;
    int                      width;
    int                      count;
    sel = word[WordWidth-1 -: SelWidth];
    payload = word[PayloadWidth-1:0];
    item.value = '0;
    item.continued = 1'b0;
    item.too_long = 1'b0;
    if (sel == SelZeroRun) begin
      if (payload > RUN_LIMIT) begin
        // overlong run collapses to one flagged zero
        item.last = 1'b1;
        item.too_long = 1'b1;
        owe_value(item);
      end else begin
        count = (payload == '0) ? 1 : int'(payload);
        for (int k = 0; k < count; k++) begin
          item.last = (k == count - 1);
          owe_value(item);
        end
      end
    end else if (sel == SelContinue) begin
      item.value = payload;
      item.continued = 1'b1;
      item.last = 1'b1;
      owe_value(item);
    end else begin
      // fields are right-aligned, most significant first
      width = field_width(sel);
      count = PayloadWidth / width;
      mask = (64'd1 << width) - 64'd1;
      for (int k = 0; k < count; k++) begin
        item.value = PayloadWidth'((64'(payload) >> ((count - 1 - k) * width)) & mask);
        item.last = (k == count - 1);
        owe_value(item);
      end
    end
  endtask

  task automatic report_mismatch(input bit owed, input decoded_value_t want,
                                 input decoded_value_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      if (owed) begin
        $display("[%0t] value mismatch: expected value=%h cont=%b last=%b long=%b",
                 $time, want.value, want.continued, want.last, want.too_long);
        $display("       got value=%h cont=%b last=%b long=%b",
                 got.value, got.continued, got.last, got.too_long);
      end else begin
        $display("[%0t] unexpected value=%h cont=%b last=%b long=%b with nothing pending",
                 $time, got.value, got.continued, got.last, got.too_long);
      end
    end
  endtask

  // Compare outgoing transfers, then record incoming words
  always @(posedge clk) begin : watch
    decoded_value_t got;
    decoded_value_t want;
    if (rst) begin
      pending_values.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.value = value;
        got.continued = continued;
        got.last = last_of_word;
        got.too_long = run_too_long;
        results_seen++;
        if (pending_values.size() == 0) begin
          want = '0;
          report_mismatch(1'b0, want, got);
        end else begin
          want = pending_values.pop_front();
          if (got.value !== want.value || got.continued !== want.continued ||
              got.last !== want.last || got.too_long !== want.too_long)
            report_mismatch(1'b1, want, got);
        end
      end
      if (in_valid && !in_stall) begin
        unpack_word(packed_word);
        words_seen++;
      end
    end
    outstanding = pending_values.size();
  end

endmodule

>>> bench/tb_simple8b_word_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_simple8b_word_decoder
// Drives packed words into the Simple-8b decoder: a directed set covering
// every selector, the zero-run corner cases and continuation words, then a
// long random stream. Both sides idle and stall at random; the checker
// instance predicts and compares every decoded value.
// ----------------------------------------------------------------------------
module tb_simple8b_word_decoder
  import s8b_pkg::*;
();

  localparam int unsigned RunLimit = 63;
  localparam int RandomWords = 330;
  localparam int CycleLimit = 5_000_000;
  localparam int SettleCycles = 70;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [WordWidth-1:0]    packed_word = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [PayloadWidth-1:0] value;
  logic                    continued;
  logic                    last_of_word;
  logic                    run_too_long;

  int mismatch_count;
  int outstanding;
  int words_seen;
  int results_seen;
  int cycle_count = 0;
  int stall_left = 0;
  int free_left = 0;
  int zero_runs = 0;
  int overlong_runs = 0;
  int continuations = 0;
  bit gaps_on = 1'b0;
  bit stalls_on = 1'b0;

  always #6 clk = ~clk;

  simple8b_word_decoder #(
    .RUN_LIMIT(RunLimit)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .packed_word (packed_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .value       (value),
    .continued   (continued),
    .last_of_word(last_of_word),
    .run_too_long(run_too_long)
  );

  s8b_decode_checker #(
    .RUN_LIMIT(RunLimit)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .packed_word   (packed_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .value         (value),
    .continued     (continued),
    .last_of_word  (last_of_word),
    .run_too_long  (run_too_long),
    .mismatch_count(mismatch_count),
    .outstanding   (outstanding),
    .words_seen    (words_seen),
    .results_seen  (results_seen)
  );

  // mostly short pauses, now and then a long one
  function automatic int pick_pause();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  // Receiver back-pressure: free stretches broken by stalls
  always @(negedge clk) begin
    if (!stalls_on) begin
      out_stall <= 1'b0;
      stall_left = 0;
      free_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (free_left > 0) begin
      out_stall <= 1'b0;
      free_left--;
    end else begin
      out_stall <= 1'b0;
      free_left = $urandom_range(12);
      stall_left = pick_pause();
    end
  end

  // Timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d values still pending", cycle_count, outstanding);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Present one word and hold it until the transfer happens
  task automatic send_word(input logic [WordWidth-1:0] word);
    int pause;
    pause = gaps_on ? pick_pause() : 0;
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(negedge clk);
    end
    in_valid <= 1'b1;
    packed_word <= word;
    do @(posedge clk); while (in_stall);
    if (word[WordWidth-1 -: SelWidth] == SelZeroRun) begin
      zero_runs++;
      if (word[PayloadWidth-1:0] > RunLimit) overlong_runs++;
    end else if (word[WordWidth-1 -: SelWidth] == SelContinue) begin
      continuations++;
    end
    @(negedge clk);
  endtask

  // Hold off the sender until every pending value has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic logic [WordWidth-1:0] random_word();
    logic [SelWidth-1:0]     sel;
    logic [PayloadWidth-1:0] payload;
    int                      roll;
    sel = SelWidth'($urandom_range(15));
    payload = PayloadWidth'({$urandom(), $urandom()});
    if (sel == SelZeroRun) begin
      roll = $urandom_range(99);
      if (roll < 75) payload = PayloadWidth'($urandom_range(RunLimit));
      else if (roll < 88) payload = PayloadWidth'(RunLimit + 1 + $urandom_range(3));
    end
    return {sel, payload};
  endfunction

  initial begin : stimulus
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero runs: empty, single, longest expanded, just over, far over
    send_word({SelZeroRun, 60'd0});
    send_word({SelZeroRun, 60'd1});
    send_word({SelZeroRun, PayloadWidth'(RunLimit)});
    send_word({SelZeroRun, PayloadWidth'(RunLimit + 1)});
    send_word({SelZeroRun, {PayloadWidth{1'b1}}});
    // continuation words at both extremes
    send_word({SelContinue, {PayloadWidth{1'b1}}});
    send_word({SelContinue, 60'd0});
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    // every field selector with all payload bits set
    for (int s = int'(SelZeroRun) + 1; s < int'(SelContinue); s++)
      send_word({SelWidth'(s), {PayloadWidth{1'b1}}});
    // unused top nibble must be ignored
    send_word({SelSevenBit, 4'hF, 56'h0});
    send_word({SelEightBit, 4'hF, 56'hA5A5_A5A5_A5A5_A5});
    send_word({SelZeroRun + 4'd1, 60'h555_5555_5555_5555});
    send_word({SelContinue - 4'd1, 60'h0});
    drain();

    // random stream with quiet stretches and pauses for a full drain
    for (int i = 0; i < RandomWords; i++) begin
      if (i == 110) begin
        gaps_on = 1'b0;
        stalls_on = 1'b0;
      end else if (i == 150) begin
        gaps_on = 1'b1;
        stalls_on = 1'b1;
      end else if (i == 230) begin
        drain();
        stalls_on = 1'b0;
      end else if (i == 260) begin
        stalls_on = 1'b1;
      end
      send_word(random_word());
    end

    drain();
    repeat (SettleCycles) @(negedge clk);

    $display("Sent %0d words (%0d zero runs, %0d overlong, %0d continuation)",
             words_seen, zero_runs, overlong_runs, continuations);
    $display("Checked %0d decoded values in %0d cycles", results_seen, cycle_count);
    if (mismatch_count == 0 && outstanding == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> sim.f
design/s8b_pkg.sv
design/simple8b_word_decoder.sv
bench/s8b_decode_checker.sv
bench/tb_simple8b_word_decoder.sv
